FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the word wrap stream unit.
// Needs nothing else; each macro takes the clock (and reset) explicitly.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("word wrap checker: assertion failed");

// Clocked assertion that also runs during reset.
`define CHK_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("word wrap checker: assertion failed");

`endif

FILE: rtl/core/gwws_pkg.sv
// Package for the greedy word wrap stream unit: codes, constants, FSM state and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package gwws_pkg;

    localparam int          CHAR_W    = 8;
    localparam int          LW_W      = 6;
    localparam int          LW_MAX    = 62;
    localparam logic [5:0]  LW_RESET  = 6'd62;

    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [7:0]  CH_TAB    = 8'h09;
    localparam logic [7:0]  CH_NL     = 8'h0A;

    // separator emitted ahead of a word
    typedef enum logic [1:0] {
        SEP_NONE,
        SEP_SPACE,
        SEP_NL
    } t_sep;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_RD,
        S_WORD,
        S_POST,
        S_FIN
    } t_state;

    typedef struct packed {
        logic take;       // input transaction accepted, plan the item
        logic emit_pre;   // load separator into output register
        logic rd;         // read word store at current index
        logic emit_word;  // load read data into output register
        logic emit_post;  // load trailing newline into output register
        logic fin;        // item done, apply deferred store write
    } t_cmd;

    typedef struct packed {
        logic pre_none;
        logic len_zero;
        logic post;
        logic idx_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/core/greedy_word_wrap_stream_unit.sv
// One item at a time: the input is not ready again until the item is done; each
// word byte emitted is a store read, then an output load, and output stalls hold it.
// The first output byte is a leading separator loaded in S_PRE, a lone newline
// loaded in S_POST, or a word byte read in S_RD and loaded in S_WORD; stalls delay it.
// Reset (i_rst_n low, synchronous): line state cleared, width back to 62,
// output register empty. The word store is not cleared.
`default_nettype none

module greedy_word_wrap_stream_unit import gwws_pkg::*; #(
    parameter int WORD_DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [LW_W-1:0]   i_cfg_wdata,   // line_width
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [CHAR_W-1:0] s_tdata,       // [7:0] char_in
    input  wire logic              s_tuser,       // [0] end_of_text
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [CHAR_W-1:0]      m_tdata,       // [7:0] char_out
    output logic                   m_tlast
);

    t_cmd cmd;
    t_sts sts;

    gwws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gwws_dp #(
        .WORD_DEPTH (WORD_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_char      (s_tdata),
        .i_eot       (s_tuser),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_out_data  (m_tdata),
        .o_out_last  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/core/gwws_ctrl.sv
// Controller FSM of the word wrap stream unit: sequences separator, word
// bytes and trailing newline of one item. Depends on gwws_pkg.
`default_nettype none

module gwws_ctrl import gwws_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_PRE;
                end
            end
            S_PRE: begin
                if (i_sts.pre_none) begin
                    n_state = i_sts.len_zero ? S_POST : S_RD;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_pre = 1'b1;
                    n_state        = i_sts.len_zero ? S_POST : S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WORD;
            end
            S_WORD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_word = 1'b1;
                    n_state         = i_sts.idx_last ? S_POST : S_RD;
                end
            end
            S_POST: begin
                if (!i_sts.post) begin
                    n_state = S_FIN;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_post = 1'b1;
                    n_state         = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/gwws_dp.sv
// Datapath of the word wrap stream unit: word store, line state, width
// register, per-item plan and the output register. Depends on gwws_pkg.
`default_nettype none

module gwws_dp import gwws_pkg::*; #(
    parameter int WORD_DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [LW_W-1:0]   i_cfg_wdata,
    input  wire logic [CHAR_W-1:0] i_char,
    input  wire logic              i_eot,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [CHAR_W-1:0]      o_out_data,
    output logic                   o_out_last
);

    localparam int AW  = $clog2(WORD_DEPTH);
    localparam int CAP = (WORD_DEPTH - 1 < LW_MAX) ? WORD_DEPTH - 1 : LW_MAX;

    logic [CHAR_W-1:0] r_mem [WORD_DEPTH];
    logic [CHAR_W-1:0] r_rdata;

    logic [AW-1:0]     r_wc,      n_wc;
    logic [LW_W-1:0]   r_col,     n_col;
    logic              r_chunk,   n_chunk;
    logic              r_started, n_started;
    logic [LW_W-1:0]   r_lw;
    logic [CHAR_W-1:0] r_char;
    logic              r_fix,     n_fix;
    t_sep              r_pre,     n_pre;
    logic [AW-1:0]     r_len,     n_len;
    logic              r_post,    n_post;
    logic [AW-1:0]     r_idx;
    logic              r_ov;
    logic [CHAR_W-1:0] r_od;
    logic              r_ol;

    logic [LW_W-1:0]   w;
    logic [7:0]        wc8, w8, col8, fit_sum;
    logic              fits;
    t_sep              f_pre;
    logic [LW_W-1:0]   f_col;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [CHAR_W-1:0] mem_data;
    logic              idx_last;
    logic              out_free;

    // effective width: zero reads as one, saturates at the smaller of WORD_DEPTH-1 and LW_MAX
    always_comb begin
        if (r_lw == '0) begin
            w = LW_W'(1);
        end else if (int'(r_lw) > CAP) begin
            w = LW_W'(CAP);
        end else begin
            w = r_lw;
        end
    end

    assign wc8     = 8'(r_wc);
    assign w8      = 8'(w);
    assign col8    = 8'(r_col);
    assign fit_sum = col8 + 8'd1 + wc8;
    assign fits    = (fit_sum <= w8);

    // placement of the pending word when it is flushed
    always_comb begin
        f_pre = SEP_NONE;
        f_col = r_col;
        if (r_wc != '0) begin
            if (r_chunk || r_col == '0) begin
                f_col = LW_W'(r_wc);
            end else if (fits) begin
                f_pre = SEP_SPACE;
                f_col = LW_W'(fit_sum);
            end else begin
                f_pre = SEP_NL;
                f_col = LW_W'(r_wc);
            end
        end
    end

    always_comb begin
        n_wc      = r_wc;
        n_col     = r_col;
        n_chunk   = r_chunk;
        n_started = r_started;
        n_pre     = r_pre;
        n_len     = r_len;
        n_post    = r_post;
        n_fix     = r_fix;
        mem_we    = 1'b0;
        mem_addr  = r_wc;
        mem_data  = i_char;
        if (i_cmd.take) begin
            n_pre  = SEP_NONE;
            n_len  = '0;
            n_post = 1'b0;
            n_fix  = 1'b0;
            if (i_eot) begin
                if (r_started) begin
                    n_pre  = f_pre;
                    n_len  = r_wc;
                    n_post = 1'b1;
                end
                n_wc      = '0;
                n_chunk   = 1'b0;
                n_col     = '0;
                n_started = 1'b0;
            end else begin
                case (i_char) inside
                    CH_NL: begin
                        n_pre     = f_pre;
                        n_len     = r_wc;
                        n_post    = 1'b1;
                        n_wc      = '0;
                        n_chunk   = 1'b0;
                        n_col     = '0;
                        n_started = 1'b0;
                    end
                    CH_SPACE, CH_TAB: begin
                        n_started = 1'b1;
                        n_pre     = f_pre;
                        n_len     = r_wc;
                        n_col     = f_col;
                        n_wc      = '0;
                        if (r_wc != '0) begin
                            n_chunk = 1'b0;
                        end
                    end
                    default: begin
                        n_started = 1'b1;
                        if (wc8 < w8) begin
                            mem_we = 1'b1;
                            n_wc   = r_wc + AW'(1);
                        end else begin
                            // word reached the width: cut a full chunk, the
                            // new byte becomes the head of the remainder
                            n_pre   = (!r_chunk && r_col != '0) ? SEP_NL : SEP_NONE;
                            n_len   = AW'(w);
                            n_post  = 1'b1;
                            n_fix   = 1'b1;
                            n_chunk = 1'b1;
                            n_wc    = AW'(1);
                            n_col   = '0;
                        end
                    end
                endcase
            end
        end else if (i_cmd.fin && r_fix) begin
            mem_we   = 1'b1;
            mem_addr = '0;
            mem_data = r_char;
            n_fix    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc      <= '0;
            r_col     <= '0;
            r_chunk   <= 1'b0;
            r_started <= 1'b0;
            r_lw      <= LW_RESET;
            r_fix     <= 1'b0;
            r_pre     <= SEP_NONE;
            r_len     <= '0;
            r_post    <= 1'b0;
        end else begin
            r_wc      <= n_wc;
            r_col     <= n_col;
            r_chunk   <= n_chunk;
            r_started <= n_started;
            r_fix     <= n_fix;
            r_pre     <= n_pre;
            r_len     <= n_len;
            r_post    <= n_post;
            // width is locked while a word is pending
            if (i_cfg_we && r_wc == '0) begin
                r_lw <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_char <= i_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    assign idx_last = (r_idx == r_len - AW'(1));
    assign out_free = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.take) begin
            r_idx <= '0;
        end else if (i_cmd.emit_word && !idx_last) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit_pre || i_cmd.emit_word || i_cmd.emit_post) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pre) begin
            r_od <= (r_pre == SEP_SPACE) ? CH_SPACE : CH_NL;
            r_ol <= 1'b0;
        end else if (i_cmd.emit_word) begin
            r_od <= r_rdata;
            r_ol <= idx_last && !r_post;
        end else if (i_cmd.emit_post) begin
            r_od <= CH_NL;
            r_ol <= 1'b1;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;
    assign o_out_last  = r_ol;

    assign o_sts.pre_none = (r_pre == SEP_NONE);
    assign o_sts.len_zero = (r_len == '0);
    assign o_sts.post     = r_post;
    assign o_sts.idx_last = idx_last;
    assign o_sts.out_free = out_free;

endmodule

`default_nettype wire

FILE: rtl/core/gwws_checker.sv
// Port-level checker for the word wrap stream unit, bound to the top level.
// Depends on gwws_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gwws_port_checker import gwws_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [CHAR_W-1:0] m_tdata,
    input wire logic              m_tlast
);

    // a stalled output transaction holds its payload
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // reset empties the output and leaves the input side ready
    `CHK_ASSERT_NR(a_reset, i_clk, !i_rst_n |=> !m_tvalid && s_tready)

    // one item in flight: an accepted transaction drops ready
    `CHK_ASSERT(a_one_item, i_clk, i_rst_n, s_tvalid && s_tready |=> !s_tready)

    // while ready for the next item, only the final byte of the last one may wait
    `CHK_ASSERT(a_idle_last, i_clk, i_rst_n, m_tvalid && s_tready |-> m_tlast)

endmodule

bind greedy_word_wrap_stream_unit gwws_port_checker u_gwws_checker (.*);

`default_nettype wire
